// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, switched off while rst_n is low.
`define ISO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("isoline check failed");

// Concurrent check sampled on clk that also holds during reset.
`define ISO_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("isoline reset check failed");

`endif

// ===== rtl/core/iso_pkg.sv =====
`timescale 1ns / 1ps
package iso_pkg;

  localparam int LEVELS   = 20;
  localparam int LVL_W    = 7;
  localparam int CFG_AW   = 4;
  localparam int IN_W     = 384;
  localparam int OUT_W    = 200;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_VALUE_MIN  = 2'd0;
  localparam logic [1:0] REG_LEVEL_STEP = 2'd1;
  localparam logic [1:0] REG_TRI_COUNT  = 2'd2;

  // One triangle as it waits in the queue.
  typedef struct packed {
    logic              done;
    logic [2:0][31:0]  val;
    logic [2:0][2:0][31:0] pos;
  } tri_t;

  // Configuration shared by front and back.
  typedef struct packed {
    logic signed [31:0] value_min;
    logic [30:0]        level_step;
    logic [19:0]        triangle_count;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LEVEL,
    B_DIV,
    B_MUL,
    B_OUT
  } back_state_t;

endpackage

// ===== rtl/core/triangle_isoline_extractor_top.sv =====
`timescale 1ns / 1ps
// Each level is classified first; a crossed level then passes through divide, multiply and output,
// while a level without crossing moves straight on to the next level.
// Throughput is set by the shared pair of serial dividers and the one multiplier in the back.
// The two-entry queue holds the triangle in work and lets the front take one more ahead.
// Reset is synchronous on rst_n low: control state clears, registers return to their defaults.
module triangle_isoline_extractor_top
  import iso_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, value_a, value_b, value_c
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // begin_x, begin_y, begin_z, end_x, end_y, end_z, level_index, zero pad
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast,
  // batch_done
  output logic              out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t cfg_r, cfg_nxt;
  logic cfg_wr;
  logic q_full, q_push, q_valid, q_pop;
  tri_t q_in, q_out;

  // Configuration register writes and reads.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt    = cfg_r;
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      REG_VALUE_MIN: begin
        cfg_prdata = cfg_r.value_min;
        if (cfg_wr) cfg_nxt.value_min = cfg_pwdata;
      end
      REG_LEVEL_STEP: begin
        cfg_prdata = {1'b0, cfg_r.level_step};
        if (cfg_wr) cfg_nxt.level_step = cfg_pwdata[30:0];
      end
      REG_TRI_COUNT: begin
        cfg_prdata = {12'd0, cfg_r.triangle_count};
        if (cfg_wr) cfg_nxt.triangle_count = cfg_pwdata[19:0];
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.value_min      <= '0;
      cfg_r.level_step     <= 31'd65536;
      cfg_r.triangle_count <= 20'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  iso_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  iso_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_out)
  );

  iso_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// ===== rtl/core/iso_div.sv =====
`timescale 1ns / 1ps
module iso_div
  import iso_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] un,
  input  logic [32:0] ud,
  output logic        busy,
  output logic [31:0] q
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic [31:0] q_r, q_nxt;
  logic [33:0] trial;

  // One quotient bit per cycle, restoring form; the first step takes no shift.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    trial    = (cnt_r == 5'd0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = un;
      den_nxt  = ud;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 33'(trial - {1'b0, den_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  // A zero denominator gives a zero fraction, so the crossing sits on the start point.
  assign busy = busy_r;
  assign q    = (den_r == 33'd0) ? 32'd0 : q_r;

endmodule

// ===== rtl/core/iso_fifo.sv =====
`timescale 1ns / 1ps
module iso_fifo
  import iso_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tri_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output tri_t pop_data
);

  tri_t       mem [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Two-entry queue between the front and the back.
  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  assign full     = cnt_r[1];
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = mem[rd_r];

endmodule

// ===== rtl/core/iso_front.sv =====
`timescale 1ns / 1ps
module iso_front
  import iso_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            q_full,
  output logic            q_push,
  output tri_t            q_data
);

  logic [19:0] seen_r, seen_nxt;
  logic        done;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Batch counter: the triangle that reaches the count closes the batch.
  always_comb begin
    done     = ({1'b0, seen_r} + 21'd1) >= {1'b0, cfg.triangle_count};
    seen_nxt = seen_r;
    if (q_push) begin
      seen_nxt = done ? 20'd0 : seen_r + 20'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign q_data.pos  = in_tdata[287:0];
  assign q_data.val  = in_tdata[383:288];
  assign q_data.done = done;

endmodule

// ===== rtl/core/iso_back.sv =====
`timescale 1ns / 1ps
module iso_back
  import iso_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  tri_t             q_data,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  back_state_t state_r, state_nxt;
  logic [LVL_W-1:0] k_r, k_nxt;
  logic signed [39:0] iso_r, iso_nxt;
  logic [2:0][2:0][31:0] p_r, p_nxt;
  logic last_r, last_nxt;
  logic [2:0] j_r, j_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [64:0] acc_r, acc_nxt;
  logic [5:0][31:0] res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic out_last_r, out_last_nxt;
  logic out_done_r, out_done_nxt;

  logic [2:0] above, above_n;
  logic [1:0] cnt, cnt_n;
  logic crossed, cross_n;
  logic [1:0] odd, s1, s2;
  logic signed [39:0] iso_next;
  logic signed [40:0] num;
  logic signed [32:0] den1, den2;
  logic [40:0] mnum;
  logic [32:0] mden1, mden2, un1, un2;
  logic start;
  logic busy1, busy2;
  logic [31:0] t1, t2;
  logic [1:0] c;
  logic signed [31:0] pa, p0;
  logic [31:0] t_sel;
  logic signed [32:0] d;
  logic [32:0] dp;
  logic [33:0] off;
  logic signed [33:0] sum;

  // Classification of the current level and look-ahead on the next one.
  always_comb begin
    iso_next = iso_r + 40'($unsigned(cfg.level_step));
    for (int i = 0; i < 3; i++) begin
      above[i]   = 40'(signed'(q_data.val[i])) > iso_r;
      above_n[i] = 40'(signed'(q_data.val[i])) > iso_next;
    end
    cnt     = 2'(above[0]) + 2'(above[1]) + 2'(above[2]);
    cnt_n   = 2'(above_n[0]) + 2'(above_n[1]) + 2'(above_n[2]);
    crossed = (cnt == 2'd1) || (cnt == 2'd2);
    cross_n = (cnt_n == 2'd1) || (cnt_n == 2'd2);
    odd = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (above[i] == (cnt == 2'd1)) begin
        odd = 2'(i);
      end
    end
    s1 = (odd == 2'd1) ? 2'd0 : 2'd1;
    s2 = (odd == 2'd2) ? 2'd0 : 2'd2;
    num   = 41'(iso_r) - 41'(signed'(q_data.val[odd]));
    den1  = 33'(signed'(q_data.val[s1])) - 33'(signed'(q_data.val[odd]));
    den2  = 33'(signed'(q_data.val[s2])) - 33'(signed'(q_data.val[odd]));
    mnum  = num[40] ? 41'(-num) : 41'(num);
    mden1 = den1[32] ? 33'(-den1) : 33'(den1);
    mden2 = den2[32] ? 33'(-den2) : 33'(den2);
    un1   = (mnum > {8'd0, mden1}) ? mden1 : mnum[32:0];
    un2   = (mnum > {8'd0, mden2}) ? mden2 : mnum[32:0];
  end

  iso_div u_div1 (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .un   (un1),
    .ud   (mden1),
    .busy (busy1),
    .q    (t1)
  );

  iso_div u_div2 (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .un   (un2),
    .ud   (mden2),
    .busy (busy2),
    .q    (t2)
  );

  // Operand selection for the shared multiplier: one coordinate at a time.
  always_comb begin
    if (j_r < 3'd3) begin
      c     = j_r[1:0];
      pa    = p_r[1][c];
      t_sel = t1;
    end else begin
      c     = 2'(j_r - 3'd3);
      pa    = p_r[2][c];
      t_sel = t2;
    end
    p0  = p_r[0][c];
    d   = 33'(pa) - 33'(p0);
    dp  = d[32] ? 33'(-d) : 33'(d);
    off = 34'((acc_r + 65'h4000_0000) >> 31);
    sum = d[32] ? 34'(p0) - signed'(off) : 34'(p0) + signed'(off);
  end

  // Level sequencer, interpolation and the output register.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    iso_nxt       = iso_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    q_pop         = 1'b0;
    start         = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          k_nxt     = LVL_W'(1);
          iso_nxt   = 40'(cfg.value_min) + 40'($unsigned(cfg.level_step));
          state_nxt = B_LEVEL;
        end
      end
      B_LEVEL: begin
        if (crossed) begin
          for (int j = 0; j < 3; j++) begin
            p_nxt[0][j] = q_data.pos[odd][j];
            p_nxt[1][j] = q_data.pos[s1][j];
            p_nxt[2][j] = q_data.pos[s2][j];
          end
          last_nxt  = !((k_r != LVL_W'(LEVELS)) && cross_n);
          start     = 1'b1;
          state_nxt = B_DIV;
        end else if (k_r == LVL_W'(LEVELS)) begin
          q_pop     = 1'b1;
          state_nxt = B_IDLE;
        end else begin
          k_nxt   = k_r + LVL_W'(1);
          iso_nxt = iso_next;
        end
      end
      B_DIV: begin
        if (!busy1 && !busy2) begin
          j_nxt     = 3'd0;
          ph_nxt    = 2'd0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        case (ph_r)
          2'd0: begin
            acc_nxt = 65'(dp[16:0] * t_sel);
            ph_nxt  = 2'd1;
          end
          2'd1: begin
            acc_nxt = acc_r + (65'(dp[32:17] * t_sel) << 17);
            ph_nxt  = 2'd2;
          end
          default: begin
            res_nxt[j_r] = sum[31:0];
            ph_nxt       = 2'd0;
            if (j_r == 3'd5) begin
              state_nxt = B_OUT;
            end else begin
              j_nxt = j_r + 3'd1;
            end
          end
        endcase
      end
      B_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, k_r, res_r};
          out_last_nxt  = last_r;
          out_done_nxt  = q_data.done;
          if (k_r == LVL_W'(LEVELS)) begin
            q_pop     = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            k_nxt     = k_r + LVL_W'(1);
            iso_nxt   = iso_next;
            state_nxt = B_LEVEL;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      ph_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      ph_r        <= ph_nxt;
    end
    iso_r      <= iso_nxt;
    p_r        <= p_nxt;
    last_r     <= last_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

// ===== rtl/core/iso_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iso_chk
  import iso_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             cfg_pready
);

  // A stalled result keeps its payload.
  `ISO_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // Every segment names a level in range and leaves the pad bit clear.
  `ISO_ASSERT(a_level_range, out_tvalid |-> out_tdata[198:192] != 7'd0 && out_tdata[198:192] <= 7'(LEVELS) && !out_tdata[199])
  // Nothing is offered in the cycle after reset.
  `ISO_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid)
  // The configuration port never waits.
  `ISO_ASSERT(a_cfg_ready, cfg_pready)

endmodule

bind triangle_isoline_extractor_top iso_chk u_chk (.*);
